>>> rtl/color_window_classifier_top_defines.svh
// ----------------------------------------------------------------------------
// color_window_classifier_top_defines
// Assertion macros for the color window classifier top level.
// ----------------------------------------------------------------------------
`ifndef COLOR_WINDOW_CLASSIFIER_TOP_DEFINES_SVH
`define COLOR_WINDOW_CLASSIFIER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define CWC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CWC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define CWC_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define CWC_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/cwc_pkg.sv
// ----------------------------------------------------------------------------
// cwc_pkg
// Types and constants of the color window classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package cwc_pkg;

   localparam int FIELD_BITS   = 16;
   localparam int FIGURE_BITS  = 32;
   localparam int COUNT_BITS   = 8;
   localparam int CSR_IDX_BITS = 3;

   // figure = (red*65536 + green*256 + blue) / clear / 10
   localparam int RED_SHIFT    = 16;
   localparam int GREEN_SHIFT  = 8;
   localparam int FIGURE_SCALE = 10;

   localparam int NUM_CLASSES = 4;

   localparam logic [2:0] CLASS_RED    = 3'd0;
   localparam logic [2:0] CLASS_GREEN  = 3'd1;
   localparam logic [2:0] CLASS_BLUE   = 3'd2;
   localparam logic [2:0] CLASS_PURPLE = 3'd3;
   localparam logic [2:0] CLASS_NONE   = 3'd4;

   localparam logic OP_CLASSIFY = 1'b0;
   localparam logic OP_CLEAR    = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] REG_CENTRE_RED    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_CENTRE_GREEN  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_CENTRE_BLUE   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_CENTRE_PURPLE = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_HALF_WIDTH    = 3'd4;

   typedef struct packed {
      logic                  op;
      logic [FIELD_BITS-1:0] clear_level;
      logic [FIELD_BITS-1:0] red_level;
      logic [FIELD_BITS-1:0] green_level;
      logic [FIELD_BITS-1:0] blue_level;
   } req_type;

   typedef struct packed {
      logic [FIGURE_BITS-1:0] colour_figure;
      logic [2:0]             class_code;
      logic                   divide_by_zero;
      logic [COUNT_BITS-1:0]  count_red;
      logic [COUNT_BITS-1:0]  count_green;
      logic [COUNT_BITS-1:0]  count_blue;
      logic [COUNT_BITS-1:0]  count_purple;
      logic [COUNT_BITS-1:0]  count_sum;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DIV   = 4'b0010,
      ST_MATCH = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

endpackage

`default_nettype wire

>>> rtl/cwc_divider.sv
// ----------------------------------------------------------------------------
// cwc_divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cwc_divider
   import cwc_pkg::*;
#(
   parameter int NUM_W = 33,
   parameter int DEN_W = 20
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numerator,
   input  wire logic [DEN_W-1:0] denominator,
   output logic                  done,
   output logic [NUM_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

   logic             running_ff, running_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   // shift in the next numerator bit and try the subtract
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      den_in     = den_ff;
      quo_in     = quo_ff;
      if (start) begin
         running_in = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         den_in     = denominator;
         quo_in     = numerator;
      end else if (running_ff) begin
         rem_in   = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in   = {quo_ff[NUM_W-2:0], fits};
         count_in = count_ff + CNT_W'(1);
         if (count_ff == LAST_STEP) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         count_ff   <= count_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> rtl/cwc_window_match.sv
// ----------------------------------------------------------------------------
// cwc_window_match
// Tests one figure against one window centre and the shared half-width.
// ----------------------------------------------------------------------------
`default_nettype none

module cwc_window_match
   import cwc_pkg::*;
(
   input  wire logic [FIGURE_BITS-1:0] figure,
   input  wire logic [FIGURE_BITS-1:0] centre,
   input  wire logic [FIGURE_BITS-1:0] half_width,
   output logic                        hit
);

   logic [FIGURE_BITS-1:0] distance;

   // |figure - centre| <= half_width is the same as the clamped window test
   assign distance = (figure >= centre) ? (figure - centre) : (centre - figure);
   assign hit      = distance <= half_width;

endmodule

`default_nettype wire

>>> rtl/color_window_classifier_top.sv
// ----------------------------------------------------------------------------
// color_window_classifier_top
// Colour figure from a four-channel light reading, window classification
// and per-class tallies.
// ----------------------------------------------------------------------------
//  channel | ports                                | direction
//  --------+--------------------------------------+----------
//  req     | req_valid, req_ready, req_data       | in
//  rsp     | rsp_valid, rsp_ready, rsp_data       | out
//  csr     | csr_valid, csr_ready, csr_index/data | in
//
//  Classify with nonzero clear: accept, the bit-serial divider, one to four
//  window compares through the one window unit, then the result load.
//  Clear op or zero clear reading: accept, then the result load.
//  req_ready is high only while idle; a result held in the output register
//  does not block the next accept, only the next result load.
//  Reset clears tallies, window registers and control; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "color_window_classifier_top_defines.svh"

module color_window_classifier_top
   import cwc_pkg::*;
#(
   parameter int CHANNEL_BITS = 16,
   parameter int TALLY_BITS   = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire req_type                 req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output rsp_type                      rsp_data,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [FIGURE_BITS-1:0]  csr_data
);

   localparam int NUM_W = CHANNEL_BITS + RED_SHIFT + 1;
   localparam int DEN_W = CHANNEL_BITS + 4;

   state_type              state_ff, state_in;
   logic                   op_ff, op_in;
   logic                   dz_ff, dz_in;
   logic [FIGURE_BITS-1:0] fig_ff, fig_in;
   logic [2:0]             class_ff, class_in;
   logic [1:0]             win_ff, win_in;
   logic [FIGURE_BITS-1:0] centre_ff [NUM_CLASSES];
   logic [FIGURE_BITS-1:0] half_width_ff;
   logic [TALLY_BITS-1:0]  tally_ff [NUM_CLASSES];
   logic [TALLY_BITS-1:0]  tally_in [NUM_CLASSES];
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                    req_fire;
   logic                    load_rsp;
   logic                    div_start;
   logic                    div_done;
   logic [NUM_W-1:0]        div_quotient;
   logic [NUM_W-1:0]        numerator;
   logic [DEN_W-1:0]        denominator;
   logic [CHANNEL_BITS-1:0] clr, red, green, blue;
   logic                    clr_zero;
   logic                    win_hit;
   logic [COUNT_BITS-1:0]   cnt [NUM_CLASSES];
   logic                    rsp_dz;
   logic                    rsp_empty;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // bits above CHANNEL_BITS are ignored
   assign clr   = req_data.clear_level[CHANNEL_BITS-1:0];
   assign red   = req_data.red_level[CHANNEL_BITS-1:0];
   assign green = req_data.green_level[CHANNEL_BITS-1:0];
   assign blue  = req_data.blue_level[CHANNEL_BITS-1:0];
   assign clr_zero = (clr == '0);

   assign numerator = (NUM_W'(red) << RED_SHIFT) + (NUM_W'(green) << GREEN_SHIFT)
                      + NUM_W'(blue);
   // floor(floor(n / c) / 10) == floor(n / (10 * c)): one pass of the divider
   assign denominator = DEN_W'(clr) * DEN_W'(FIGURE_SCALE);

   assign div_start = req_fire && (req_data.op == OP_CLASSIFY) && !clr_zero;

   cwc_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (numerator),
      .denominator (denominator),
      .done        (div_done),
      .quotient    (div_quotient)
   );

   cwc_window_match u_window (
      .figure     (fig_ff),
      .centre     (centre_ff[win_ff]),
      .half_width (half_width_ff),
      .hit        (win_hit)
   );

   assign load_rsp = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      dz_in    = dz_ff;
      fig_in   = fig_ff;
      class_in = class_ff;
      win_in   = win_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_data.op;
               dz_in    = (req_data.op == OP_CLASSIFY) && clr_zero;
               fig_in   = '0;
               class_in = CLASS_NONE;
               win_in   = '0;
               state_in = div_start ? ST_DIV : ST_EMIT;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               fig_in   = FIGURE_BITS'(div_quotient);
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            // first window that holds the figure wins
            if (win_hit) begin
               class_in = {1'b0, win_ff};
               state_in = ST_EMIT;
            end else if (win_ff == 2'(NUM_CLASSES - 1)) begin
               class_in = CLASS_NONE;
               state_in = ST_EMIT;
            end else begin
               win_in = win_ff + 2'd1;
            end
         end
         ST_EMIT: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
         tally_in[i] = tally_ff[i];
         if (load_rsp) begin
            if (op_ff == OP_CLEAR) begin
               tally_in[i] = '0;
            end else if (class_ff == 3'(i)) begin
               tally_in[i] = tally_ff[i] + TALLY_BITS'(1);
            end
         end
         cnt[i] = COUNT_BITS'(tally_in[i]);
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in          = 1'b1;
         rsp_in.colour_figure  = fig_ff;
         rsp_in.class_code     = class_ff;
         rsp_in.divide_by_zero = dz_ff;
         rsp_in.count_red      = cnt[CLASS_RED[1:0]];
         rsp_in.count_green    = cnt[CLASS_GREEN[1:0]];
         rsp_in.count_blue     = cnt[CLASS_BLUE[1:0]];
         rsp_in.count_purple   = cnt[CLASS_PURPLE[1:0]];
         rsp_in.count_sum      = COUNT_BITS'(cnt[0] + cnt[1] + cnt[2] + cnt[3]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         half_width_ff <= '0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            tally_ff[i]  <= '0;
            centre_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            tally_ff[i] <= tally_in[i];
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_CENTRE_RED:    centre_ff[0] <= csr_data;
               REG_CENTRE_GREEN:  centre_ff[1] <= csr_data;
               REG_CENTRE_BLUE:   centre_ff[2] <= csr_data;
               REG_CENTRE_PURPLE: centre_ff[3] <= csr_data;
               REG_HALF_WIDTH:    half_width_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
      op_ff    <= op_in;
      dz_ff    <= dz_in;
      fig_ff   <= fig_in;
      class_ff <= class_in;
      win_ff   <= win_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign rsp_dz    = rsp_valid && rsp_data.divide_by_zero;
   assign rsp_empty = (rsp_data.class_code == CLASS_NONE) && (rsp_data.colour_figure == '0);

   `CWC_ASSERT_NXT(a_start_div, clock, reset, div_start, state_ff == ST_DIV, "divide not started")
   `CWC_ASSERT_IMP(a_done_in_div, clock, reset, div_done, state_ff == ST_DIV, "stray divide done")
   `CWC_ASSERT_IMP(a_dz_result, clock, reset, rsp_dz, rsp_empty, "zero clear result not empty")
   `CWC_ASSERT_IMP(a_load_room, clock, reset, load_rsp && rsp_valid_ff, rsp_ready, "lost result")

endmodule

`default_nettype wire

>>> verif/tb_color_window_classifier_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_color_window_classifier_top
// Self-checking bench for the color window classifier. Light readings go in
// over the req channel and window settings over the csr channel. A scoreboard
// works out each report (figure, class, tallies) and checks every report that
// comes back on the rsp channel, in order. Window boundaries, overlapping
// windows, zero clear readings, tally wrap and random traffic are covered,
// with random idling on both sides and long holds on the result side.
// ----------------------------------------------------------------------------
module tb_color_window_classifier_top;
   import cwc_pkg::*;

   localparam int STALL_LIMIT   = 4000;
   localparam int LONG_HOLD     = 400;
   localparam int HOLD_EVERY    = 1500;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 60;
   localparam int REG_COUNT     = 5;
   localparam longint unsigned NUMER_CAP = 64'hFFFF_FFFF;

   // windows are tried in this order; the first hit wins
   localparam logic [2:0] CLASS_ORDER [NUM_CLASSES] =
      '{CLASS_RED, CLASS_GREEN, CLASS_BLUE, CLASS_PURPLE};
   localparam logic [CSR_IDX_BITS-1:0] REG_ORDER [REG_COUNT] =
      '{REG_CENTRE_RED, REG_CENTRE_GREEN, REG_CENTRE_BLUE, REG_CENTRE_PURPLE,
        REG_HALF_WIDTH};

   class classifier_scoreboard;
      logic [FIGURE_BITS-1:0] centre [NUM_CLASSES];
      logic [FIGURE_BITS-1:0] half_width;
      logic [COUNT_BITS-1:0]  tally [NUM_CLASSES];
      rsp_type                predicted_reports [$];
      int                     errors;

      function new();
         for (int k = 0; k < NUM_CLASSES; k++) begin
            centre[k] = '0;
            tally[k]  = '0;
         end
         half_width = '0;
         errors     = 0;
      endfunction

      function void set_register(logic [CSR_IDX_BITS-1:0] idx,
                                 logic [FIGURE_BITS-1:0] value);
         case (idx)
            REG_CENTRE_RED:    centre[CLASS_RED]    = value;
            REG_CENTRE_GREEN:  centre[CLASS_GREEN]  = value;
            REG_CENTRE_BLUE:   centre[CLASS_BLUE]   = value;
            REG_CENTRE_PURPLE: centre[CLASS_PURPLE] = value;
            REG_HALF_WIDTH:    half_width           = value;
            default: ;
         endcase
      endfunction

      // lower edge clamps at zero, upper edge keeps its carry
      function bit in_window(logic [FIGURE_BITS-1:0] figure,
                             logic [FIGURE_BITS-1:0] mid);
         logic [FIGURE_BITS:0] lo;
         logic [FIGURE_BITS:0] hi;
         lo = (mid > half_width) ? {1'b0, mid - half_width} : '0;
         hi = {1'b0, mid} + {1'b0, half_width};
         return ({1'b0, figure} >= lo) && ({1'b0, figure} <= hi);
      endfunction

      function void note_reading(req_type item);
         rsp_type              rpt;
         logic [FIGURE_BITS:0] numer;
         logic [FIGURE_BITS:0] quot;
         logic [2:0]           cls;
         rpt = '0;
         cls = CLASS_NONE;
         if (item.op == OP_CLEAR) begin
            for (int k = 0; k < NUM_CLASSES; k++) tally[k] = '0;
         end else if (item.clear_level == '0) begin
            rpt.divide_by_zero = 1'b1;
         end else begin
            numer = ({17'b0, item.red_level} << RED_SHIFT)
                  + ({17'b0, item.green_level} << GREEN_SHIFT)
                  + {17'b0, item.blue_level};
            quot = numer / {17'b0, item.clear_level};
            quot = quot / FIGURE_SCALE;
            rpt.colour_figure = quot[FIGURE_BITS-1:0];
            for (int k = 0; k < NUM_CLASSES; k++) begin
               if (cls == CLASS_NONE &&
                   in_window(rpt.colour_figure, centre[CLASS_ORDER[k]])) begin
                  cls = CLASS_ORDER[k];
                  tally[cls] = tally[cls] + 1'b1;
               end
            end
         end
         rpt.class_code   = cls;
         rpt.count_red    = tally[CLASS_RED];
         rpt.count_green  = tally[CLASS_GREEN];
         rpt.count_blue   = tally[CLASS_BLUE];
         rpt.count_purple = tally[CLASS_PURPLE];
         rpt.count_sum    = tally[CLASS_RED] + tally[CLASS_GREEN]
                          + tally[CLASS_BLUE] + tally[CLASS_PURPLE];
         predicted_reports.push_back(rpt);
      endfunction

      function void check_field(string field, longint unsigned want,
                                longint unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (predicted_reports.size() == 0) begin
            $error("report with no reading outstanding: %h", got);
            errors++;
            return;
         end
         want = predicted_reports.pop_front();
         check_field("colour_figure",  want.colour_figure,  got.colour_figure);
         check_field("class_code",     want.class_code,     got.class_code);
         check_field("divide_by_zero", want.divide_by_zero, got.divide_by_zero);
         check_field("count_red",      want.count_red,      got.count_red);
         check_field("count_green",    want.count_green,    got.count_green);
         check_field("count_blue",     want.count_blue,     got.count_blue);
         check_field("count_purple",   want.count_purple,   got.count_purple);
         check_field("count_sum",      want.count_sum,      got.count_sum);
      endfunction

      function int pending();
         return predicted_reports.size();
      endfunction
   endclass

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   req_type                 req_data  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [FIGURE_BITS-1:0]  csr_data  = '0;
   bit                      steady_traffic = 1'b0;
   classifier_scoreboard    sb;

   color_window_classifier_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      if (steady_traffic) return 0;
      roll = $urandom_range(99, 0);
      if (roll < 50) return 0;
      if (roll < 88) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic req_type random_reading();
      req_type item;
      item = req_type'({1'b0, $urandom, $urandom});
      case ($urandom_range(9, 0))
         0: item.clear_level = '0;
         1: item.clear_level = 16'($urandom_range(15, 1));
         2: item.clear_level = 16'hFFFF;
         default: ;
      endcase
      return item;
   endfunction

   // exact split of a numerator over the three color channels, with a random
   // share moved down from red so green and blue reach their upper bits
   function automatic req_type reading_for(longint unsigned numer,
                                           int unsigned clear);
      req_type         item;
      longint unsigned rest;
      longint unsigned borrow;
      longint unsigned g_lo;
      longint unsigned g_hi;
      item.op          = OP_CLASSIFY;
      item.clear_level = 16'(clear);
      item.red_level   = 16'(numer >> RED_SHIFT);
      rest   = numer & 64'hFFFF;
      borrow = $urandom_range((item.red_level < 255) ? item.red_level : 255, 0);
      item.red_level = item.red_level - 16'(borrow);
      rest = rest + (borrow << RED_SHIFT);
      g_lo = (rest > 65535) ? (rest - 65535 + 255) >> GREEN_SHIFT : 0;
      g_hi = rest >> GREEN_SHIFT;
      item.green_level = 16'($urandom_range(32'(g_hi), 32'(g_lo)));
      item.blue_level  = 16'(rest - (longint'(item.green_level) << GREEN_SHIFT));
      return item;
   endfunction

   // reading whose figure lands just outside, on an edge of, or inside one of the windows
   function automatic req_type aimed_reading();
      longint unsigned mid;
      longint unsigned span;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned target;
      longint unsigned c_top;
      longint unsigned numer;
      int unsigned     clear;
      mid  = sb.centre[CLASS_ORDER[$urandom_range(NUM_CLASSES - 1, 0)]];
      span = sb.half_width;
      lo   = (mid > span) ? mid - span : 0;
      hi   = mid + span;
      case ($urandom_range(5, 0))
         0: target = lo - 1;
         1: target = lo;
         2: target = hi;
         3: target = hi + 1;
         default: target = lo + ({$urandom, $urandom} % (hi - lo + 1));
      endcase
      if (target > NUMER_CAP) return random_reading();
      c_top = NUMER_CAP / (FIGURE_SCALE * target + FIGURE_SCALE);
      if (c_top == 0) return random_reading();
      if (c_top > 65535) c_top = 65535;
      if ($urandom_range(1, 0) == 0)
         clear = $urandom_range((c_top < 8) ? 32'(c_top) : 8, 1);
      else
         clear = $urandom_range(32'(c_top), 1);
      numer = (target * FIGURE_SCALE + $urandom_range(FIGURE_SCALE - 1, 0)) * clear
            + $urandom_range(clear - 1, 0);
      return reading_for(numer, clear);
   endfunction

   task automatic send_reading(req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_reading(item);
   endtask

   task automatic write_register(logic [CSR_IDX_BITS-1:0] idx,
                                 logic [FIGURE_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(idx, value);
   endtask

   // waits for every report before touching the windows
   task automatic program_windows(logic [FIGURE_BITS-1:0] red_mid, green_mid,
                                  blue_mid, purple_mid, span);
      logic [FIGURE_BITS-1:0]  value [REG_COUNT];
      logic [CSR_IDX_BITS-1:0] spare;
      value = '{red_mid, green_mid, blue_mid, purple_mid, span};
      spare = REG_HALF_WIDTH + 3'($urandom_range(3, 1));
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      for (int k = 0; k < REG_COUNT; k++) write_register(REG_ORDER[k], value[k]);
      write_register(spare, $urandom);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(int count, int clear_permille, int aimed_pct,
                            bit no_gaps);
      req_type item;
      steady_traffic = no_gaps;
      repeat (count) begin
         if ($urandom_range(99, 0) < aimed_pct) item = aimed_reading();
         else item = random_reading();
         item.op = ($urandom_range(999, 0) < clear_permille) ? OP_CLEAR : OP_CLASSIFY;
         send_reading(item);
      end
      steady_traffic = 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   // result side: random holds, plus a long one now and then
   initial begin : result_sink
      int stall;
      int turns;
      turns = 0;
      forever begin
         @(posedge clock);
         turns++;
         stall = (turns % HOLD_EVERY == 0) ? LONG_HOLD : pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $error("no transaction for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      int unsigned boundary_figs [11] =
         '{899, 900, 1100, 1101, 1900, 2100, 2900, 3100, 3900, 4100, 4101};
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset windows all sit on figure zero with no width
      send_reading(req_type'{OP_CLASSIFY, 16'd1, 16'd0, 16'd0, 16'd0});
      send_reading(req_type'{OP_CLASSIFY, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF});
      send_reading(req_type'{OP_CLASSIFY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
      send_reading(req_type'{OP_CLASSIFY, 16'hFFFF, 16'd0, 16'd0, 16'd0});
      send_reading(req_type'{OP_CLASSIFY, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF});
      send_reading(req_type'{OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});

      // on each window edge, and just outside the lowest and highest edges
      program_windows(32'd1000, 32'd2000, 32'd3000, 32'd4000, 32'd100);
      foreach (boundary_figs[k])
         send_reading(reading_for(boundary_figs[k] * FIGURE_SCALE +
                                  $urandom_range(FIGURE_SCALE - 1, 0), 1));

      // top centre with no width misses; zero figure falls to green
      program_windows(32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0);
      send_reading(req_type'{OP_CLASSIFY, 16'd1, 16'd0, 16'd0, 16'd0});
      // widest window from the top centre must still cover everything
      program_windows(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
      send_reading(req_type'{OP_CLASSIFY, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF});

      program_windows($urandom_range(20000, 0), $urandom_range(20000, 0),
                      $urandom_range(20000, 0), $urandom_range(20000, 0),
                      $urandom_range(500, 0));
      run_phase(250, 20, 70, 1'b0);

      // overlapping windows exercise the priority order
      program_windows($urandom_range(5000, 0), $urandom_range(5000, 0),
                      $urandom_range(5000, 0), $urandom_range(5000, 0),
                      $urandom_range(5000, 1000));
      run_phase(200, 15, 70, 1'b1);

      // every reading with nonzero clear lands in the first window, so its tally wraps
      program_windows($urandom, $urandom, $urandom, $urandom, 32'hFFFF_FFFF);
      run_phase(300, 0, 50, 1'b0);

      program_windows($urandom, $urandom, $urandom, $urandom, $urandom);
      run_phase(150, 30, 40, 1'b0);

      program_windows($urandom_range(400000000, 0), $urandom_range(400000000, 0),
                      $urandom_range(400000000, 0), $urandom_range(400000000, 0),
                      $urandom_range(2000000, 0));
      run_phase(150, 20, 70, 1'b0);

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> color_window_classifier_top.f
+incdir+rtl
rtl/cwc_pkg.sv
rtl/cwc_divider.sv
rtl/cwc_window_match.sv
rtl/color_window_classifier_top.sv
verif/tb_color_window_classifier_top.sv
